/* hdl/bct_pkg.sv */
// Shared types and constants of the button countdown timer.
`default_nettype none

package bct_pkg;

  // Divider limits; each divider counts from 1 up to its limit, then fires.
  localparam int unsigned ScanLimit    = 5;
  localparam int unsigned SampleLimit  = 10;
  localparam int unsigned RefreshLimit = 100;

  // Divider widths.
  localparam int unsigned ScanW    = 3;
  localparam int unsigned SampleW  = 4;
  localparam int unsigned RefreshW = 7;
  localparam int unsigned StepW    = 10;

  // Countdown step lengths in ticks.
  localparam logic [StepW-1:0] StepSlow = 10'd1000;
  localparam logic [StepW-1:0] StepMid  = 10'd100;
  localparam logic [StepW-1:0] StepFast = 10'd10;

  // Field widths.
  localparam int unsigned ButtonW = 6;
  localparam int unsigned MinuteW = 7;
  localparam int unsigned SecondW = 6;
  localparam int unsigned DutyW   = 10;

  localparam logic [SecondW-1:0] SecondTop = 6'd59;
  localparam logic [DutyW-1:0]   DutyFull  = 10'd1023;
  localparam logic [DutyW-1:0]   DutyOff   = 10'd0;

  // Button positions within the button level field.
  localparam int unsigned BtnClear = 0;
  localparam int unsigned BtnStart = 1;
  localparam int unsigned BtnStop  = 2;
  localparam int unsigned BtnSlow  = 3;
  localparam int unsigned BtnMid   = 4;
  localparam int unsigned BtnFast  = 5;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  // Pulses produced by the tick dividers for the current word.
  typedef struct packed {
    logic scan;
    logic sample;
    logic refresh;
  } bct_tick_t;

endpackage

`default_nettype wire

/* hdl/bct_tick_div.sv */
// Fixed tick dividers for scan, button sample and refresh pulses.
`default_nettype none

module bct_tick_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  output bct_pkg::bct_tick_t      tick_o
);
  import bct_pkg::*;

  logic [ScanW-1:0]    scan_q, scan_d;
  logic [SampleW-1:0]  sample_q, sample_d;
  logic [RefreshW-1:0] refresh_q, refresh_d;

  // Each divider fires at its limit and restarts at one.
  always_comb begin
    tick_o.scan    = (scan_q >= ScanW'(ScanLimit));
    tick_o.sample  = (sample_q >= SampleW'(SampleLimit));
    tick_o.refresh = (refresh_q >= RefreshW'(RefreshLimit));
    scan_d    = tick_o.scan    ? ScanW'(1)    : scan_q + ScanW'(1);
    sample_d  = tick_o.sample  ? SampleW'(1)  : sample_q + SampleW'(1);
    refresh_d = tick_o.refresh ? RefreshW'(1) : refresh_q + RefreshW'(1);
  end

  // Dividers advance once per word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= ScanW'(1);
      sample_q  <= SampleW'(1);
      refresh_q <= RefreshW'(1);
    end else if (en_i) begin
      scan_q    <= scan_d;
      sample_q  <= sample_d;
      refresh_q <= refresh_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/bct_countdown.sv */
// Button handling, step divider and mm:ss countdown state.
`default_nettype none

module bct_countdown (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire bct_pkg::bct_tick_t            tick_i,
  input  wire logic [bct_pkg::ButtonW-1:0]   levels_i,
  input  wire logic [bct_pkg::MinuteW-1:0]   preset_minute_i,
  input  wire logic [bct_pkg::SecondW-1:0]   preset_second_i,
  output logic [bct_pkg::MinuteW-1:0]        minute_o,
  output logic [bct_pkg::SecondW-1:0]        second_o,
  output logic                               running_o,
  output logic [bct_pkg::DutyW-1:0]          duty_o,
  output logic                               allowed_o
);
  import bct_pkg::*;

  logic [StepW-1:0]   step_div_q, step_div_d;
  logic [StepW-1:0]   step_len_q, step_len_d;
  logic [ButtonW-1:0] last_q, last_d;
  logic               active_q, active_d;
  logic               adjust_q, adjust_d;
  logic [MinuteW-1:0] minute_q, minute_d;
  logic [SecondW-1:0] second_q, second_d;
  logic [DutyW-1:0]   duty_q, duty_d;

  logic [ButtonW-1:0] falls;
  logic               step_fire;
  logic [SecondW-1:0] second_dec;

  // Button actions on a sample tick, then the countdown step.
  always_comb begin
    falls      = '0;
    last_d     = last_q;
    step_len_d = step_len_q;
    active_d   = active_q;
    adjust_d   = adjust_q;
    minute_d   = minute_q;
    second_d   = second_q;
    duty_d     = duty_q;
    second_dec = '0;

    if (tick_i.sample) begin
      falls  = last_q & ~levels_i;
      last_d = levels_i;
    end
    if (falls[BtnClear]) begin
      minute_d = '0;
      second_d = '0;
      adjust_d = 1'b0;
      duty_d   = DutyFull;
    end
    if (falls[BtnStart]) begin
      adjust_d = 1'b0;
      active_d = 1'b1;
      minute_d = preset_minute_i;
      second_d = preset_second_i;
    end
    if (falls[BtnStop]) begin
      active_d = 1'b0;
      adjust_d = 1'b1;
      duty_d   = DutyOff;
    end
    if (falls[BtnSlow]) step_len_d = StepSlow;
    if (falls[BtnMid])  step_len_d = StepMid;
    if (falls[BtnFast]) step_len_d = StepFast;

    // The step divider compares against any length just chosen.
    step_fire  = (step_div_q >= step_len_d);
    step_div_d = step_fire ? StepW'(1) : step_div_q + StepW'(1);

    // One second down, borrowing from minutes; reaching zero finishes.
    if (step_fire && active_d) begin
      if (second_d == '0) begin
        if (minute_d != '0) begin
          second_d = SecondTop;
          minute_d = minute_d - MinuteW'(1);
        end else begin
          active_d = 1'b0;
          duty_d   = DutyFull;
        end
      end else begin
        second_dec = second_d - SecondW'(1);
        second_d   = second_dec;
        if (minute_d == '0 && second_dec == '0) begin
          active_d = 1'b0;
          duty_d   = DutyFull;
        end
      end
    end
  end

  assign minute_o  = minute_d;
  assign second_o  = second_d;
  assign running_o = active_d;
  assign duty_o    = duty_d;
  assign allowed_o = adjust_d;

  // State advances once per word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_div_q <= StepW'(1);
      step_len_q <= StepSlow;
      last_q     <= '1;
      active_q   <= 1'b0;
      adjust_q   <= 1'b1;
      minute_q   <= '0;
      second_q   <= '0;
      duty_q     <= DutyOff;
    end else if (en_i) begin
      step_div_q <= step_div_d;
      step_len_q <= step_len_d;
      last_q     <= last_d;
      active_q   <= active_d;
      adjust_q   <= adjust_d;
      minute_q   <= minute_d;
      second_q   <= second_d;
      duty_q     <= duty_d;
    end
  end

`ifndef SYNTHESIS
  // The step length only ever takes one of the three button choices.
  a_step_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_len_q == StepSlow || step_len_q == StepMid || step_len_q == StepFast)
    else $error("step length left the legal set");

  // The step divider never rests at zero and never passes the longest step.
  a_step_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_div_q != '0 && step_div_q <= StepSlow)
    else $error("step divider out of range");

  // A countdown that stops without a stop press has driven full duty.
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && active_q && !active_d && !falls[BtnStop] |=> duty_q == DutyFull)
    else $error("countdown finished without full duty");
`endif

endmodule

`default_nettype wire

/* hdl/button_countdown_timer.sv */
// Top level: input register, tick dividers, countdown logic, result register.
// A result word passes through the input register and then the result register.
// Throughput is one word per cycle while the result side takes words; the input
// register refills while the result register is taken, and the state update is one pass of logic.
// Reset sets all dividers to one, the step length to 1000 ticks, the button
// history to released, the time to 00:00, duty to 0 and adjusting enabled.
`default_nettype none

module button_countdown_timer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // button_levels[5:0], preset_minute[12:6], preset_second[18:13], zeros above
  input  wire logic [bct_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // shown_minute[6:0], shown_second[12:7], running[13], drive_duty[23:14],
  // setting_allowed[24], scan_pulse[25], refresh_pulse[26], zeros above
  output logic [bct_pkg::OutDataW-1:0]       m_axis_tdata_o
);
  import bct_pkg::*;

  logic               in_valid_q, in_valid_d;
  logic [ButtonW-1:0] levels_q;
  logic [MinuteW-1:0] pmin_q;
  logic [SecondW-1:0] psec_q;
  logic               out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic               advance;
  bct_tick_t          tick;
  logic [MinuteW-1:0] minute;
  logic [SecondW-1:0] second;
  logic               running;
  logic [DutyW-1:0]   duty;
  logic               allowed;

  // A word moves on when the result register is empty or being taken.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign in_valid_d  = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      levels_q <= s_axis_tdata_i[ButtonW-1:0];
      pmin_q   <= s_axis_tdata_i[ButtonW +: MinuteW];
      psec_q   <= s_axis_tdata_i[ButtonW+MinuteW +: SecondW];
    end
  end

  bct_tick_div u_tick_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .tick_o (tick)
  );

  bct_countdown u_countdown (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .tick_i          (tick),
    .levels_i        (levels_q),
    .preset_minute_i (pmin_q),
    .preset_second_i (psec_q),
    .minute_o        (minute),
    .second_o        (second),
    .running_o       (running),
    .duty_o          (duty),
    .allowed_o       (allowed)
  );

  // Pack the result word.
  assign out_data_d = {5'd0, tick.refresh, tick.scan, allowed, duty, running,
                       second, minute};

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the button countdown timer stream block.
`timescale 1ns / 100ps

module tb_top;
  import bct_pkg::*;

  localparam int unsigned DirectedItems = 30;
  localparam int unsigned RandomItems   = 1460;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned SqueezeAfter  = 600;
  localparam int unsigned SqueezeLength = 300;
  localparam logic [ButtonW-1:0] AllReleased = '1;

  // One input word: a 1 ms tick with button levels and preset time.
  typedef struct packed {
    logic [ButtonW-1:0] levels;
    logic [MinuteW-1:0] preset_min;
    logic [SecondW-1:0] preset_sec;
  } tick_t;

  // One result word as the block reports it after a tick.
  typedef struct packed {
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic               running;
    logic [DutyW-1:0]   duty;
    logic               allowed;
    logic               scan;
    logic               refresh;
  } reading_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data  = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  tick_t       tick_q[$];
  reading_t    readings_q[$];
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned readings_seen = 0;
  int          send_gap;
  int          rx_hold;
  bit          squeezed;
  logic        quiet;

  // Predicted block state.
  logic [ScanW-1:0]    scan_div;
  logic [SampleW-1:0]  sample_div;
  logic [StepW-1:0]    step_div;
  logic [RefreshW-1:0] refresh_div;
  logic [StepW-1:0]    step_len;
  logic [ButtonW-1:0]  prev_buttons;
  logic                active;
  logic                adjust;
  logic [MinuteW-1:0]  min_left;
  logic [SecondW-1:0]  sec_left;
  logic [DutyW-1:0]    duty;

  button_countdown_timer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Long stretches every so often where neither side idles.
  assign quiet = (cycle_count[9:8] == 2'b11);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ButtonW-1:0] press(int unsigned btn);
    logic [ButtonW-1:0] lv;
    lv      = AllReleased;
    lv[btn] = 1'b0;
    return lv;
  endfunction

  function automatic logic [InDataW-1:0] pack_tick(tick_t t);
    return InDataW'({t.preset_sec, t.preset_min, t.levels});
  endfunction

  task automatic add_run(input logic [ButtonW-1:0] lv, input logic [MinuteW-1:0] pm,
                         input logic [SecondW-1:0] ps, input int unsigned n);
    tick_t t;
    t.levels     = lv;
    t.preset_min = pm;
    t.preset_sec = ps;
    repeat (n) tick_q.push_back(t);
  endtask

  task automatic reset_state();
    scan_div     = ScanW'(1);
    sample_div   = SampleW'(1);
    step_div     = StepW'(1);
    refresh_div  = RefreshW'(1);
    step_len     = StepSlow;
    prev_buttons = AllReleased;
    active       = 1'b0;
    adjust       = 1'b1;
    min_left     = '0;
    sec_left     = '0;
    duty         = DutyOff;
  endtask

  // Advance the predicted state by one tick and report the resulting reading.
  task automatic advance_tick(input tick_t t, output reading_t r);
    logic [ButtonW-1:0] falls;
    r = '0;

    if (scan_div < ScanLimit) begin
      scan_div = scan_div + 1'b1;
    end else begin
      r.scan   = 1'b1;
      scan_div = ScanW'(1);
    end

    // Buttons act on falling edges, in order of their position.
    if (sample_div < SampleLimit) begin
      sample_div = sample_div + 1'b1;
    end else begin
      falls = prev_buttons & ~t.levels;
      if (falls[BtnClear]) begin
        min_left = '0;
        sec_left = '0;
        adjust   = 1'b0;
        duty     = DutyFull;
      end
      if (falls[BtnStart]) begin
        adjust   = 1'b0;
        active   = 1'b1;
        min_left = t.preset_min;
        sec_left = t.preset_sec;
      end
      if (falls[BtnStop]) begin
        active = 1'b0;
        adjust = 1'b1;
        duty   = DutyOff;
      end
      if (falls[BtnSlow]) step_len = StepSlow;
      if (falls[BtnMid])  step_len = StepMid;
      if (falls[BtnFast]) step_len = StepFast;
      prev_buttons = t.levels;
      sample_div   = SampleW'(1);
    end

    // Countdown step; reaching or sitting at 00:00 finishes the run.
    if (step_div < step_len) begin
      step_div = step_div + 1'b1;
    end else begin
      if (active) begin
        if (sec_left == 0) begin
          if (min_left != 0) begin
            sec_left = SecondTop;
            min_left = min_left - 1'b1;
          end else begin
            active = 1'b0;
            duty   = DutyFull;
          end
        end else begin
          sec_left = sec_left - 1'b1;
          if (min_left == 0 && sec_left == 0) begin
            active = 1'b0;
            duty   = DutyFull;
          end
        end
      end
      step_div = StepW'(1);
    end

    if (refresh_div < RefreshLimit) begin
      refresh_div = refresh_div + 1'b1;
    end else begin
      r.refresh   = 1'b1;
      refresh_div = RefreshW'(1);
    end

    r.minute  = min_left;
    r.second  = sec_left;
    r.running = active;
    r.duty    = duty;
    r.allowed = adjust;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Input driver: offers queued words and predicts each one as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t next_reading;
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      s_data   <= '0;
      send_gap = 0;
      reset_state();
    end else begin
      if (s_valid && s_ready) begin
        advance_tick(tick_q.pop_front(), next_reading);
        readings_q.push_back(next_reading);
        if (!quiet && $urandom_range(0, 99) < 20) send_gap = pick_gap();
      end
      if (s_valid && !s_ready) begin
        // The current word stays on offer until it is taken.
      end else if (send_gap > 0) begin
        send_gap--;
        s_valid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        s_valid <= 1'b1;
        s_data  <= pack_tick(tick_q[0]);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Output monitor: checks each result word and throttles the ready line.
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      m_ready  <= 1'b0;
      rx_hold  = 0;
      squeezed = 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        readings_seen++;
        if (readings_q.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          fail_count++;
        end else begin
          want = readings_q.pop_front();
          check_field("shown_minute",    32'(want.minute),  32'(m_data[6:0]));
          check_field("shown_second",    32'(want.second),  32'(m_data[12:7]));
          check_field("running",         32'(want.running), 32'(m_data[13]));
          check_field("drive_duty",      32'(want.duty),    32'(m_data[23:14]));
          check_field("setting_allowed", 32'(want.allowed), 32'(m_data[24]));
          check_field("scan_pulse",      32'(want.scan),    32'(m_data[25]));
          check_field("refresh_pulse",   32'(want.refresh), 32'(m_data[26]));
        end
      end
      // One long hold-off so that the block fills and stalls its input.
      if (rx_hold > 0) begin
        rx_hold--;
        m_ready <= 1'b0;
      end else if (!squeezed && readings_seen >= SqueezeAfter) begin
        squeezed = 1'b1;
        rx_hold  = SqueezeLength;
        m_ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        rx_hold = pick_gap() - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned           pick;
    int unsigned           step_btn;
    logic [MinuteW-1:0]    pm;
    logic [SecondW-1:0]    ps;

    // Directed: start at 00:00 with the fast step chosen in the same sample,
    // which also shortens the step to the current divider value; then every
    // button at once with out of range presets at their widest.
    add_run(AllReleased, '0, '0, 5);
    add_run(press(BtnStart) & press(BtnFast), '0, '0, 10);
    add_run(AllReleased, '1, '1, 5);
    add_run('0, '1, '1, 10);

    // Random: mostly complete countdown sequences, the rest noise.
    while (tick_q.size() < DirectedItems + RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pick     = $urandom_range(0, 99);
        step_btn = (pick < 60) ? BtnFast : (pick < 85) ? BtnMid : BtnSlow;
        add_run(AllReleased, MinuteW'($urandom_range(0, 127)),
                SecondW'($urandom_range(0, 63)), $urandom_range(10, 20));
        add_run(press(step_btn), MinuteW'($urandom_range(0, 127)),
                SecondW'($urandom_range(0, 63)), $urandom_range(10, 15));
        add_run(AllReleased, MinuteW'($urandom_range(0, 127)),
                SecondW'($urandom_range(0, 63)), $urandom_range(10, 15));
        pm = ($urandom_range(0, 9) == 0) ? MinuteW'($urandom_range(0, 127))
                                         : MinuteW'($urandom_range(0, 1));
        ps = ($urandom_range(0, 9) == 0) ? SecondW'($urandom_range(0, 63))
                                         : SecondW'($urandom_range(0, 4));
        add_run(press(BtnStart), pm, ps, $urandom_range(10, 15));
        add_run(AllReleased, MinuteW'($urandom_range(0, 127)),
                SecondW'($urandom_range(0, 63)), $urandom_range(10, 120));
        case ($urandom_range(0, 3))
          0: add_run(press(BtnStop), '0, '0, $urandom_range(10, 15));
          1: add_run(press(BtnClear), '0, '0, $urandom_range(10, 15));
          default: ;
        endcase
      end else begin
        add_run(ButtonW'($urandom_range(0, 63)), MinuteW'($urandom_range(0, 127)),
                SecondW'($urandom_range(0, 63)), $urandom_range(1, 25));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (tick_q.size() != 0 || s_valid || readings_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
